// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bcrd_pkg.sv =====
// types and constants for the button chatter release delay block
`default_nettype none

package bcrd_pkg;

  localparam int MAX_BUTTONS = 2;
  localparam int DEF_NUM_BUTTONS = 2;

  localparam logic [15:0] HOLD_RESET = 16'd50;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP = 1'd1;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ACT_PASS  = 2'd0;
  localparam logic [1:0] ACT_BLOCK = 2'd1;
  localparam logic [1:0] ACT_SYNTH = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic tick;
    logic arm;
    logic cancel;
  } btn_cmd_t;

  typedef struct packed {
    logic        pending;
    logic        expire;
    logic [15:0] held_x;
    logic [15:0] held_y;
  } btn_stat_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        button;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/bcrd_btn.sv =====
// per-button release countdown and latched position
`default_nettype none

module bcrd_btn (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcrd_pkg::btn_cmd_t cmd,
  input  wire logic [15:0]        hold,
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  output bcrd_pkg::btn_stat_t     stat
);

  logic        pending_r, pending_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] held_x_r, held_y_r;
  logic        done;

  assign done = (remaining_r <= 16'd1);

  always_comb begin
    pending_nxt   = pending_r;
    remaining_nxt = remaining_r;
    priority if (cmd.arm) begin
      pending_nxt   = 1'b1;
      remaining_nxt = hold;
    end else if (cmd.cancel) begin
      pending_nxt   = 1'b0;
      remaining_nxt = 16'd0;
    end else if (cmd.tick && pending_r) begin
      if (done) begin
        pending_nxt   = 1'b0;
        remaining_nxt = 16'd0;
      end else begin
        remaining_nxt = remaining_r - 16'd1;
      end
    end else begin
      pending_nxt   = pending_r;
      remaining_nxt = remaining_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      remaining_r <= 16'd0;
    end else begin
      pending_r   <= pending_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  // position latch
  always_ff @(posedge clk) begin
    if (cmd.arm) begin
      held_x_r <= pos_x;
      held_y_r <= pos_y;
    end
  end

  assign stat.pending = pending_r;
  assign stat.expire  = pending_r && done;
  assign stat.held_x  = held_x_r;
  assign stat.held_y  = held_y_r;

endmodule

`default_nettype wire

// ===== hdl/bcrd_outq.sv =====
// result queue: per cycle up to two results in, one beat out unless stalled
`default_nettype none

module bcrd_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     push_n,
  input  wire bcrd_pkg::res_t res0,
  input  wire bcrd_pkg::res_t res1,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bcrd_pkg::res_t      out_res
);

  localparam logic [bcrd_pkg::QCNT_W-1:0] FULL_LVL =
    bcrd_pkg::QCNT_W'(bcrd_pkg::QDEPTH - 2);

  bcrd_pkg::res_t mem [bcrd_pkg::QDEPTH];

  logic [bcrd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bcrd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bcrd_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign full      = (count_r > FULL_LVL);
  assign out_res   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + bcrd_pkg::QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + bcrd_pkg::QPTR_W'(pop);
    count_nxt  = count_r + bcrd_pkg::QCNT_W'(push_n) - bcrd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + bcrd_pkg::QPTR_W'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_chatter_release_delay.sv =====
// top level of the mouse button chatter filter with delayed release
//
// input channel (in_*): one beat per event: tick, press or release, with
// button, injected flag and pointer position. result channel (out_*): one
// beat per result: pass, block or synthetic release, with last marking the
// final result of an event. press and release give one result, a tick gives
// one synthetic release per expiring button (button 0 first) or none.
// kind three is dropped without a result.
// each result is registered in the result queue and handed out in order.
// throughput: one event per cycle unless stalled; a tick that expires both
// buttons puts two beats in the four-entry result queue, which then drains
// one per cycle unless stalled. in_stall rises when the queue holds more
// than two beats; the event decision and button state update happen in
// the cycle of acceptance. a stalled result holds and further events are
// taken until the queue fills. cfg_we writes hold_ticks (index 0) or
// swap_buttons (index 1). reset (rst_n low, synchronous) empties the queue,
// stops all countdowns and restores hold_ticks to 50 and swap_buttons to 0.
`default_nettype none

module button_chatter_release_delay #(
  parameter int NUM_BUTTONS = bcrd_pkg::DEF_NUM_BUTTONS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bcrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcrd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic                            in_button,
  input  wire logic                            in_injected,
  input  wire logic signed [15:0]              in_pos_x,
  input  wire logic signed [15:0]              in_pos_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_action,
  output logic                                 out_button,
  output logic signed [15:0]                   out_x,
  output logic signed [15:0]                   out_y,
  output logic                                 out_last
);

  localparam bit TWO_BUTTONS = (NUM_BUTTONS > 1);

  logic [15:0] hold_r;
  logic        swap_r;

  bcrd_pkg::btn_cmd_t  cmd  [bcrd_pkg::MAX_BUTTONS];
  bcrd_pkg::btn_stat_t stat [bcrd_pkg::MAX_BUTTONS];

  bcrd_pkg::res_t res0, res1, out_res;
  logic [1:0]     push_n;
  logic           accept;
  logic           btn_ok;
  logic           sel_pending;
  logic           full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= bcrd_pkg::HOLD_RESET;
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcrd_pkg::REG_HOLD: hold_r <= cfg_data;
        bcrd_pkg::REG_SWAP: swap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < bcrd_pkg::MAX_BUTTONS; gi++) begin : g_btn
      if (gi < NUM_BUTTONS) begin : g_on
        bcrd_btn u_btn (
          .clk   (clk),
          .rst_n (rst_n),
          .cmd   (cmd[gi]),
          .hold  (hold_r),
          .pos_x (in_pos_x),
          .pos_y (in_pos_y),
          .stat  (stat[gi])
        );
      end else begin : g_off
        assign stat[gi] = '0;
      end
    end
  endgenerate

  assign accept      = in_valid && !in_stall;
  assign btn_ok      = TWO_BUTTONS || (in_button == 1'b0);
  assign sel_pending = in_button ? stat[1].pending : stat[0].pending;

  always_comb begin
    for (int i = 0; i < bcrd_pkg::MAX_BUTTONS; i++) begin
      cmd[i] = '0;
    end
    res0   = '0;
    res1   = '0;
    push_n = 2'd0;
    case (in_kind)
      bcrd_pkg::KIND_TICK: begin
        for (int i = 0; i < bcrd_pkg::MAX_BUTTONS; i++) begin
          cmd[i].tick = accept;
        end
        if (stat[0].expire) begin
          res0 = '{action: bcrd_pkg::ACT_SYNTH, button: swap_r,
                   x: stat[0].held_x, y: stat[0].held_y, last: !stat[1].expire};
          res1 = '{action: bcrd_pkg::ACT_SYNTH, button: !swap_r,
                   x: stat[1].held_x, y: stat[1].held_y, last: 1'b1};
          push_n = stat[1].expire ? 2'd2 : 2'd1;
        end else if (stat[1].expire) begin
          res0 = '{action: bcrd_pkg::ACT_SYNTH, button: !swap_r,
                   x: stat[1].held_x, y: stat[1].held_y, last: 1'b1};
          push_n = 2'd1;
        end
      end
      bcrd_pkg::KIND_PRESS: begin
        res0.last = 1'b1;
        push_n    = 2'd1;
        if (btn_ok && sel_pending) begin
          res0.action           = bcrd_pkg::ACT_BLOCK;
          cmd[in_button].cancel = accept;
        end else begin
          res0.action = bcrd_pkg::ACT_PASS;
        end
      end
      bcrd_pkg::KIND_RELEASE: begin
        res0.last = 1'b1;
        push_n    = 2'd1;
        if (!btn_ok || in_injected) begin
          res0.action = bcrd_pkg::ACT_PASS;
        end else begin
          res0.action        = bcrd_pkg::ACT_BLOCK;
          cmd[in_button].arm = accept;
        end
      end
      default: ;
    endcase
  end

  bcrd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (accept ? push_n : 2'd0),
    .res0      (res0),
    .res1      (res1),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign in_stall   = full;
  assign out_action = out_res.action;
  assign out_button = out_res.button;
  assign out_x      = out_res.x;
  assign out_y      = out_res.y;
  assign out_last   = out_res.last;

endmodule

`default_nettype wire

// ===== hdl/bcrd_checker.sv =====
// port-level checks for the chatter filter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bcrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_action,
  input wire logic        out_button,
  input wire logic [15:0] out_x,
  input wire logic [15:0] out_y,
  input wire logic        out_last
);

  logic in_beat_event;
  logic out_plain;

  assign in_beat_event = in_valid && !in_stall &&
    (in_kind == bcrd_pkg::KIND_PRESS || in_kind == bcrd_pkg::KIND_RELEASE);
  assign out_plain = out_valid && (out_action != bcrd_pkg::ACT_SYNTH);

  `ASSERT_IMP(a_plain_zero, out_plain, out_button == 1'b0 && out_x == 16'd0 && out_y == 16'd0, "pass or block beat carries payload")
  `ASSERT_IMP(a_plain_last, out_plain, out_last, "pass or block beat without last")
  `ASSERT_NXT(a_event_result, in_beat_event && !out_valid, out_valid, "press or release gave no beat")
  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_action) && $stable(out_x) && $stable(out_y) && $stable(out_last), "stalled beat changed")

endmodule

bind button_chatter_release_delay bcrd_checker u_bcrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_kind    (in_kind),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_action (out_action),
  .out_button (out_button),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_last   (out_last)
);

`default_nettype wire

// ===== bench/tb_button_chatter_release_delay.sv =====
// testbench for the button chatter release delay block
`default_nettype none

module tb_button_chatter_release_delay;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TICK_SPAN_CAP = 60;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bcrd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcrd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      in_kind;
  logic                            in_button;
  logic                            in_injected;
  logic signed [15:0]              in_pos_x;
  logic signed [15:0]              in_pos_y;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      out_action;
  logic                            out_button;
  logic signed [15:0]              out_x;
  logic signed [15:0]              out_y;
  logic                            out_last;

  // filter state as the block should hold it
  logic [15:0] hold_cfg;
  logic        swap_cfg;
  logic        countdown_on [bcrd_pkg::MAX_BUTTONS];
  logic [15:0] ticks_left [bcrd_pkg::MAX_BUTTONS];
  logic [15:0] latch_x [bcrd_pkg::MAX_BUTTONS];
  logic [15:0] latch_y [bcrd_pkg::MAX_BUTTONS];

  bcrd_pkg::res_t decisions_q[$];
  bcrd_pkg::res_t head_res;
  int   error_count = 0;
  int   cycle_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  button_chatter_release_delay #(
    .NUM_BUTTONS(2)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_button  (in_button),
    .in_injected(in_injected),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_action (out_action),
    .out_button (out_button),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_button_chatter_release_delay: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic note_error(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  // compare each accepted result beat with the oldest expected decision
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decisions_q.size() == 0) begin
        note_error("result beat with no decision expected");
      end else begin
        head_res = decisions_q.pop_front();
        if (out_action !== head_res.action)
          note_error($sformatf("action got %0d want %0d", out_action, head_res.action));
        if (out_button !== head_res.button)
          note_error($sformatf("button got %0d want %0d", out_button, head_res.button));
        if (out_x !== head_res.x)
          note_error($sformatf("x got %04h want %04h", out_x, head_res.x));
        if (out_y !== head_res.y)
          note_error($sformatf("y got %04h want %04h", out_y, head_res.y));
        if (out_last !== head_res.last)
          note_error($sformatf("last got %0d want %0d", out_last, head_res.last));
      end
    end
  end

  function automatic void filter_event(input logic [1:0] kind, input logic btn,
                                       input logic inj, input logic [15:0] x,
                                       input logic [15:0] y);
    bcrd_pkg::res_t r;
    int   fired;
    int   i;
    r = '0;
    fired = 0;
    if (kind == bcrd_pkg::KIND_TICK) begin
      for (i = 0; i < bcrd_pkg::MAX_BUTTONS; i++) begin
        if (countdown_on[i]) begin
          if (ticks_left[i] <= 16'd1) begin
            countdown_on[i] = 1'b0;
            ticks_left[i] = '0;
            r.action = bcrd_pkg::ACT_SYNTH;
            r.button = i[0] ^ swap_cfg;
            r.x = latch_x[i];
            r.y = latch_y[i];
            r.last = 1'b0;
            decisions_q.push_back(r);
            fired++;
          end else begin
            ticks_left[i] = ticks_left[i] - 16'd1;
          end
        end
      end
      if (fired > 0) begin
        r = decisions_q[decisions_q.size()-1];
        r.last = 1'b1;
        decisions_q[decisions_q.size()-1] = r;
      end
    end else if (kind != KIND_UNUSED) begin
      r.last = 1'b1;
      r.action = bcrd_pkg::ACT_PASS;
      if (kind == bcrd_pkg::KIND_PRESS) begin
        if (countdown_on[btn]) begin
          countdown_on[btn] = 1'b0;
          ticks_left[btn] = '0;
          r.action = bcrd_pkg::ACT_BLOCK;
        end
      end else if (!inj) begin
        latch_x[btn] = x;
        latch_y[btn] = y;
        ticks_left[btn] = hold_cfg;
        countdown_on[btn] = 1'b1;
        r.action = bcrd_pkg::ACT_BLOCK;
      end
      decisions_q.push_back(r);
    end
  endfunction

  task automatic send_beat(input logic [1:0] kind, input logic btn, input logic inj,
                           input logic [15:0] x, input logic [15:0] y);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_button   <= btn;
    in_injected <= inj;
    in_pos_x    <= x;
    in_pos_y    <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_event(kind, btn, inj, x, y);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcrd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcrd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == bcrd_pkg::REG_HOLD)
      hold_cfg = val;
    else
      swap_cfg = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] hold, input logic swap,
                            input int gp, input int sp);
    settle_idle();
    write_reg(bcrd_pkg::REG_HOLD, hold);
    write_reg(bcrd_pkg::REG_SWAP, {{(bcrd_pkg::CFG_DATA_W-1){1'b0}}, swap});
    gap_pct = gp;
    stall_pct = sp;
  endtask

  function automatic logic [15:0] rnd_pos();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int tick_span();
    int s;
    s = (hold_cfg == 16'd0) ? 2 : int'(hold_cfg) + 1;
    return (s > TICK_SPAN_CAP) ? TICK_SPAN_CAP : s;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_beat(bcrd_pkg::KIND_TICK, 1'($urandom), 1'($urandom), rnd_pos(),
                         rnd_pos());
  endtask

  // mostly well-formed release / tick / bounce sequences, some noise
  task automatic chatter_traffic(input int count);
    int       sent;
    int       pick;
    int       burst;
    logic     b;
    logic [1:0] k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      b = 1'($urandom);
      if (pick < 40) begin
        send_beat(bcrd_pkg::KIND_RELEASE, b, 1'b0, rnd_pos(), rnd_pos());
        burst = $urandom_range(tick_span());
        send_ticks(burst);
        sent += burst + 1;
      end else if (pick < 65) begin
        send_beat(bcrd_pkg::KIND_RELEASE, b, 1'b0, rnd_pos(), rnd_pos());
        burst = $urandom_range(tick_span() / 2);
        send_ticks(burst);
        send_beat(bcrd_pkg::KIND_PRESS, b, 1'($urandom), rnd_pos(), rnd_pos());
        sent += burst + 2;
      end else if (pick < 80) begin
        send_beat(bcrd_pkg::KIND_RELEASE, b, 1'b0, rnd_pos(), rnd_pos());
        send_beat(bcrd_pkg::KIND_RELEASE, ~b, 1'b0, rnd_pos(), rnd_pos());
        burst = tick_span();
        send_ticks(burst);
        sent += burst + 2;
      end else begin
        k = 2'($urandom_range(3));
        send_beat(k, b, 1'($urandom), rnd_pos(), rnd_pos());
        if (k != KIND_UNUSED) sent++;
      end
    end
  endtask

  task automatic test_directed();
    set_filter(16'd2, 1'b0, 0, 0);
    send_beat(bcrd_pkg::KIND_PRESS, 1'b0, 1'b0, 16'h1234, 16'h5678);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b0, 1'b0, 16'h8000, 16'h7FFF);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b1, 1'b0, 16'h7FFF, 16'h8000);
    send_beat(bcrd_pkg::KIND_TICK, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    // injected beats pass straight through
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
    send_beat(bcrd_pkg::KIND_PRESS, 1'b1, 1'b1, 16'h0000, 16'h0000);
    // bounce: release then press cancels the countdown
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b1, 1'b0, 16'h0001, 16'hFFFE);
    send_beat(bcrd_pkg::KIND_PRESS, 1'b1, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(KIND_UNUSED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    // both buttons expire on the same tick, re-arm on left
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b1, 1'b0, 16'hFFFF, 16'h0000);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b0, 1'b0, 16'h4000, 16'hC000);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    // zero hold expires on the next tick, swapped codes
    set_filter(16'd0, 1'b1, 0, 0);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b1, 1'b0, 16'h2AAA, 16'hD555);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(bcrd_pkg::KIND_RELEASE, 1'b0, 1'b0, 16'h5555, 16'hAAAA);
    send_beat(bcrd_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_short_hold();
    set_filter(16'd1, 1'b0, 0, 0);
    chatter_traffic(300);
  endtask

  task automatic test_sender_gaps();
    set_filter(16'd3, 1'b1, 75, 0);
    chatter_traffic(300);
  endtask

  task automatic test_receiver_stalls();
    set_filter(16'd0, 1'b1, 0, 75);
    chatter_traffic(300);
  endtask

  task automatic test_both_idle();
    set_filter(16'd9, 1'b0, 15, 15);
    chatter_traffic(300);
  endtask

  task automatic test_default_hold();
    set_filter(bcrd_pkg::HOLD_RESET, 1'b0, 0, 75);
    chatter_traffic(300);
  endtask

  task automatic test_max_hold();
    set_filter(16'hFFFF, 1'b1, 15, 15);
    chatter_traffic(200);
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_kind     <= bcrd_pkg::KIND_TICK;
    in_button   <= 1'b0;
    in_injected <= 1'b0;
    in_pos_x    <= '0;
    in_pos_y    <= '0;
    hold_cfg = bcrd_pkg::HOLD_RESET;
    swap_cfg = 1'b0;
    for (int i = 0; i < bcrd_pkg::MAX_BUTTONS; i++) begin
      countdown_on[i] = 1'b0;
      ticks_left[i] = '0;
      latch_x[i] = '0;
      latch_y[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_short_hold();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_default_hold();
    test_max_hold();

    settle_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_button_chatter_release_delay: clean");
    else
      $display("tb_button_chatter_release_delay: errors");
    $finish;
  end

endmodule

`default_nettype wire
